/* sv/frnc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the circle radius table of the neighbor counter.
// No dependencies.
package frnc_pkg;

   localparam int MAX_POINTS    = 64;
   localparam int COORD_BITS    = 14;
   localparam int INDEX_BITS    = 6;
   localparam int RSQ_BITS      = 28;
   localparam int PCOUNT_BITS   = 7;
   localparam int MASK_BITS     = 64;
   localparam int NEAR_BITS     = 6;
   localparam int RADIUS_BITS   = 20;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam int IDX_BITS      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int LIM_BITS      = $clog2(MAX_POINTS + 1);
   localparam int MASK_SEL_BITS = $clog2(MASK_BITS);
   localparam int POINT_BITS    = 2 * COORD_BITS;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int SQ_BITS       = 2 * COORD_BITS + 1;
   localparam int SUM_BITS      = SQ_BITS + 1;
   localparam int CMP_BITS      = (SUM_BITS > RSQ_BITS) ? SUM_BITS : RSQ_BITS;

   localparam logic [RSQ_BITS-1:0]    RSQ_RESET    = RSQ_BITS'(640000);
   localparam logic [PCOUNT_BITS-1:0] PCOUNT_RESET = PCOUNT_BITS'(64);
   localparam int                     RAD_MAX_EXP  = 27;
   localparam logic [RADIUS_BITS-1:0] RAD_SAT      = {RADIUS_BITS{1'b1}};
   localparam int                     NEAR_MAX     = 63;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic REG_RSQ    = 1'b0;
   localparam logic REG_PCOUNT = 1'b1;

   typedef struct packed {
      logic                busy;
      logic                valid;
      logic                hit;
      logic [IDX_BITS-1:0] tag;
   } hit_type;

   // 1.5^n, 4 fraction bits (raw 16 * 1.5^n), rounded to nearest, saturating
   function automatic logic [RADIUS_BITS-1:0] circle_radius_of(input logic [IDX_BITS-1:0] n);
      logic [4:0]             e;
      logic [RADIUS_BITS-1:0] r;
      e = 5'(n);
      unique case (e)
         5'd0:    r = 20'd16;
         5'd1:    r = 20'd24;
         5'd2:    r = 20'd36;
         5'd3:    r = 20'd54;
         5'd4:    r = 20'd81;
         5'd5:    r = 20'd122;
         5'd6:    r = 20'd182;
         5'd7:    r = 20'd273;
         5'd8:    r = 20'd410;
         5'd9:    r = 20'd615;
         5'd10:   r = 20'd923;
         5'd11:   r = 20'd1384;
         5'd12:   r = 20'd2076;
         5'd13:   r = 20'd3114;
         5'd14:   r = 20'd4671;
         5'd15:   r = 20'd7006;
         5'd16:   r = 20'd10509;
         5'd17:   r = 20'd15764;
         5'd18:   r = 20'd23646;
         5'd19:   r = 20'd35469;
         5'd20:   r = 20'd53204;
         5'd21:   r = 20'd79806;
         5'd22:   r = 20'd119709;
         5'd23:   r = 20'd179564;
         5'd24:   r = 20'd269346;
         5'd25:   r = 20'd404019;
         5'd26:   r = 20'd606028;
         5'd27:   r = 20'd909042;
         default: r = RAD_SAT;
      endcase
      if (int'(n) > RAD_MAX_EXP) begin
         r = RAD_SAT;
      end
      return r;
   endfunction

endpackage

/* sv/fixed_radius_neighbor_count.sv */
`timescale 1ns / 1ps
// Fixed-radius neighbor counter, top level: sequencer, CSRs, result register.
// Query beat: stored points below limit are scanned, limit = min(point_count, 64); next
// beat accepted once the result is registered; a new result waits while an older one
// is unread. One stored point per cycle through the distance unit.
// Synchronous active-high reset clears control and presets CSRs; point store is kept.
// Depends on frnc_pkg, frnc_point_mem, frnc_dist_unit.
module fixed_radius_neighbor_count
   import frnc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [INDEX_BITS-1:0]    req_index,
   input  logic [COORD_BITS-1:0]    req_x_pos,
   input  logic [COORD_BITS-1:0]    req_y_pos,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MASK_BITS-1:0]     rsp_neighbor_mask,
   output logic [NEAR_BITS-1:0]     rsp_near_total,
   output logic [RADIUS_BITS-1:0]   rsp_circle_radius,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_LATCH = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [INDEX_BITS-1:0]   qidx_ff, qidx_in;
   logic [LIM_BITS-1:0]     limit_ff, limit_in;
   logic [LIM_BITS-1:0]     scan_k_ff, scan_k_in;
   logic [POINT_BITS-1:0]   qpt_ff, qpt_in;
   logic                    vld1_ff, vld1_in;
   logic [IDX_BITS-1:0]     tag1_ff, tag1_in;
   logic [MASK_BITS-1:0]    mask_ff, mask_in;
   logic [IDX_BITS-1:0]     cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MASK_BITS-1:0]    rsp_mask_ff, rsp_mask_in;
   logic [NEAR_BITS-1:0]    rsp_near_ff, rsp_near_in;
   logic [RADIUS_BITS-1:0]  rsp_rad_ff, rsp_rad_in;
   logic [RSQ_BITS-1:0]     rsq_ff, rsq_in;
   logic [PCOUNT_BITS-1:0]  pcount_ff, pcount_in;

   logic                    req_beat, csr_write, idx_ok;
   logic                    mem_wr_en;
   logic [IDX_BITS-1:0]     mem_rd_addr;
   logic [POINT_BITS-1:0]   mem_rd_data;
   logic [MASK_SEL_BITS-1:0] mask_sel;
   hit_type                 hit;

   assign req_beat  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx_ok    = int'(req_index) < MAX_POINTS;
   assign mem_wr_en = req_beat && (req_func == FUNC_LOAD) && idx_ok;
   assign mask_sel  = MASK_SEL_BITS'(hit.tag);

   frnc_point_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (IDX_BITS'(req_index)),
      .wr_data ({req_x_pos, req_y_pos}),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   frnc_dist_unit u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld1_ff),
      .in_tag      (tag1_ff),
      .query_point (qpt_ff),
      .cand_point  (mem_rd_data),
      .radius_sq   (rsq_ff),
      .result      (hit)
   );

   always_comb begin
      rsq_in    = rsq_ff;
      pcount_in = pcount_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_RSQ:    rsq_in    = csr_pwdata[RSQ_BITS-1:0];
            REG_PCOUNT: pcount_in = csr_pwdata[PCOUNT_BITS-1:0];
            default:    rsq_in    = rsq_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_RSQ:    csr_prdata = CSR_DATA_BITS'(rsq_ff);
         REG_PCOUNT: csr_prdata = CSR_DATA_BITS'(pcount_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      qidx_in      = qidx_ff;
      limit_in     = limit_ff;
      scan_k_in    = scan_k_ff;
      qpt_in       = qpt_ff;
      vld1_in      = 1'b0;
      tag1_in      = scan_k_ff[IDX_BITS-1:0];
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_near_in  = rsp_near_ff;
      rsp_rad_in   = rsp_rad_ff;
      mem_rd_addr  = scan_k_ff[IDX_BITS-1:0];

      if (hit.valid && hit.hit) begin
         cnt_in = cnt_ff + IDX_BITS'(1);
         if (int'(hit.tag) < MASK_BITS) begin
            mask_in[mask_sel] = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_func == FUNC_QUERY) begin
               qidx_in  = req_index;
               mask_in  = '0;
               cnt_in   = '0;
               limit_in = (int'(pcount_ff) > MAX_POINTS) ? LIM_BITS'(MAX_POINTS)
                                                         : LIM_BITS'(pcount_ff);
               state_in = idx_ok ? ST_FETCH : ST_DONE;
            end
         end
         ST_FETCH: begin
            mem_rd_addr = IDX_BITS'(qidx_ff);
            state_in    = ST_LATCH;
         end
         ST_LATCH: begin
            qpt_in    = mem_rd_data;
            scan_k_in = '0;
            state_in  = (limit_ff == '0) ? ST_DRAIN : ST_SCAN;
         end
         ST_SCAN: begin
            vld1_in   = int'(scan_k_ff) != int'(qidx_ff);
            scan_k_in = scan_k_ff + LIM_BITS'(1);
            if (scan_k_ff == limit_ff - LIM_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!vld1_ff && !hit.busy && !hit.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_ff;
               rsp_near_in  = (int'(cnt_ff) > NEAR_MAX) ? NEAR_BITS'(NEAR_MAX)
                                                        : NEAR_BITS'(cnt_ff);
               rsp_rad_in   = circle_radius_of(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld1_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsq_ff       <= RSQ_RESET;
         pcount_ff    <= PCOUNT_RESET;
      end else begin
         state_ff     <= state_in;
         vld1_ff      <= vld1_in;
         rsp_valid_ff <= rsp_valid_in;
         rsq_ff       <= rsq_in;
         pcount_ff    <= pcount_in;
      end
   end

   always_ff @(posedge clock) begin
      qidx_ff     <= qidx_in;
      limit_ff    <= limit_in;
      scan_k_ff   <= scan_k_in;
      qpt_ff      <= qpt_in;
      tag1_ff     <= tag1_in;
      mask_ff     <= mask_in;
      cnt_ff      <= cnt_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_near_ff <= rsp_near_in;
      rsp_rad_ff  <= rsp_rad_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_neighbor_mask = rsp_mask_ff;
   assign rsp_near_total    = rsp_near_ff;
   assign rsp_circle_radius = rsp_rad_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> int'(scan_k_ff) < int'(limit_ff))
      else $error("scan index past limit");

   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> int'(cnt_ff) == $countones(mask_ff))
      else $error("neighbor count disagrees with mask");

   a_hit_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      hit.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("distance result outside scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside done state");

endmodule

/* sv/frnc_point_mem.sv */
`timescale 1ns / 1ps
// Point store: one write port, one registered read port.
// Depends on frnc_pkg.
module frnc_point_mem
   import frnc_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_BITS-1:0]   wr_addr,
   input  logic [POINT_BITS-1:0] wr_data,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output logic [POINT_BITS-1:0] rd_data
);

   logic [POINT_BITS-1:0] mem [MAX_POINTS];
   logic [POINT_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/frnc_dist_unit.sv */
`timescale 1ns / 1ps
// Shared squared distance unit: subtract and square, then add and compare.
// Two register stages, one point per cycle. Depends on frnc_pkg.
module frnc_dist_unit
   import frnc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [IDX_BITS-1:0]   in_tag,
   input  logic [POINT_BITS-1:0] query_point,
   input  logic [POINT_BITS-1:0] cand_point,
   input  logic [RSQ_BITS-1:0]   radius_sq,
   output hit_type               result
);

   logic signed [COORD_BITS-1:0]  qx, qy, cx, cy;
   logic signed [DIFF_BITS-1:0]   dx, dy;
   logic signed [2*DIFF_BITS-1:0] prod_x, prod_y;
   logic [SUM_BITS-1:0]           sum;

   logic                s1_valid_ff, s1_valid_in;
   logic [IDX_BITS-1:0] s1_tag_ff;
   logic [SQ_BITS-1:0]  sqx_ff, sqy_ff;
   logic                s2_valid_ff, s2_valid_in;
   logic [IDX_BITS-1:0] s2_tag_ff;
   logic                s2_hit_ff, s2_hit_in;

   assign qx = query_point[POINT_BITS-1:COORD_BITS];
   assign qy = query_point[COORD_BITS-1:0];
   assign cx = cand_point[POINT_BITS-1:COORD_BITS];
   assign cy = cand_point[COORD_BITS-1:0];

   assign dx = DIFF_BITS'(qx) - DIFF_BITS'(cx);
   assign dy = DIFF_BITS'(qy) - DIFF_BITS'(cy);
   assign prod_x = dx * dx;
   assign prod_y = dy * dy;

   assign sum = SUM_BITS'(sqx_ff) + SUM_BITS'(sqy_ff);
   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;
   assign s2_hit_in = CMP_BITS'(sum) < CMP_BITS'(radius_sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= in_tag;
      sqx_ff    <= prod_x[SQ_BITS-1:0];
      sqy_ff    <= prod_y[SQ_BITS-1:0];
      s2_tag_ff <= s1_tag_ff;
      s2_hit_ff <= s2_hit_in;
   end

   assign result.busy  = s1_valid_ff;
   assign result.valid = s2_valid_ff;
   assign result.hit   = s2_hit_ff;
   assign result.tag   = s2_tag_ff;

endmodule
